>>> hdl/lmcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types, codes and default geometry for the double-buffered LED matrix
// column scan unit.
// ----------------------------------------------------------------------------
package lmcs_pkg;

    localparam int DEF_COLUMNS_PER_ELEMENT = 8;
    localparam int DEF_ELEMENTS_PER_BOARD  = 6;
    localparam int DEF_BOARDS_PER_LINE     = 3;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // decoded command handed from the front end to the back end
    typedef struct packed {
        logic              is_scan;
        logic [BYTE_W-1:0] load_byte;
        logic [COL_W-1:0]  column;
        logic              pix_en;
        logic [BYTE_W-1:0] sel_byte;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_SELECT
    } t_scan_state;

endpackage

>>> hdl/lmcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_front
// Input stage: accepts items, decodes them into commands and registers them
// for the command queue.
// ----------------------------------------------------------------------------
module lmcs_front #(
    parameter int COLUMNS_PER_ELEMENT = lmcs_pkg::DEF_COLUMNS_PER_ELEMENT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [lmcs_pkg::BYTE_W-1:0] i_load_byte,
    input  logic [lmcs_pkg::COL_W-1:0]  i_column,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output lmcs_pkg::t_cmd              o_cmd
);
    import lmcs_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.is_scan   = (i_opcode == OP_SCAN);
        n_cmd.load_byte = i_load_byte;
        n_cmd.column    = i_column;
        // columns past the element width shift out blank pixels
        n_cmd.pix_en    = ({1'b0, i_column} < (COL_W + 1)'(COLUMNS_PER_ELEMENT));
        n_cmd.sel_byte  = ~(BYTE_W'(1) << i_column);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hdl/lmcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_queue
// Two-entry command queue between the front end and the scan back end.
// ----------------------------------------------------------------------------
module lmcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  lmcs_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output lmcs_pkg::t_cmd o_pop_cmd
);
    import lmcs_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wptr] <= i_push_cmd;
        end
    end

endmodule

>>> hdl/lmcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_back
// Back end: holds both bitmap banks, executes loads and sequences column
// scans through a read stage and an output register.
// ----------------------------------------------------------------------------
module lmcs_back #(
    parameter int COLUMNS_PER_ELEMENT = lmcs_pkg::DEF_COLUMNS_PER_ELEMENT,
    parameter int ELEMENTS_PER_BOARD  = lmcs_pkg::DEF_ELEMENTS_PER_BOARD,
    parameter int BOARDS_PER_LINE     = lmcs_pkg::DEF_BOARDS_PER_LINE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  lmcs_pkg::t_cmd              i_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lmcs_pkg::BYTE_W-1:0] o_shift_byte,
    output logic                        o_is_select,
    output logic                        o_latch
);
    import lmcs_pkg::*;

    localparam int ELEMENTS  = ELEMENTS_PER_BOARD * BOARDS_PER_LINE;
    localparam int DB        = ELEMENTS * COLUMNS_PER_ELEMENT;
    localparam int MEM_DEPTH = 2 * DB;
    localparam int MW        = $clog2(MEM_DEPTH);
    localparam int PW        = $clog2(DB + 1);
    localparam int EW        = $clog2(ELEMENTS + 1);
    localparam int SW        = $clog2(ELEMENTS_PER_BOARD + 1);
    localparam int LAST_BASE = (ELEMENTS - 1) * COLUMNS_PER_ELEMENT;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];

    t_scan_state       r_state;
    t_scan_state       n_state;

    // bank control
    logic              r_show;
    logic              r_disp_valid;
    logic [PW-1:0]     r_pos;

    // scan counters
    logic [EW-1:0]     r_elem;
    logic [EW-1:0]     n_elem;
    logic [SW-1:0]     r_sub;
    logic [SW-1:0]     n_sub;
    logic [PW-1:0]     r_addr;
    logic [PW-1:0]     n_addr;
    logic              r_use_mem;
    logic [BYTE_W-1:0] r_sel_byte;

    // read stage
    logic              r_s1_valid;
    logic              r_s1_use_mem;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_sel;
    logic              r_s1_last;
    logic [BYTE_W-1:0] r_rd_data;

    // output register
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_sel;
    logic              r_o_last;

    logic              w_adv_out;
    logic              w_issue_ok;
    logic              w_start;
    logic              w_issue_pix;
    logic              w_issue_sel;
    logic              w_we;
    logic              w_re;
    logic [EW-1:0]     w_cur_elem;
    logic [SW-1:0]     w_cur_sub;
    logic [PW-1:0]     w_cur_addr;
    logic              w_cur_use_mem;
    logic [BYTE_W-1:0] w_cur_sel_byte;
    logic [MW-1:0]     w_wr_idx;
    logic [MW-1:0]     w_rd_idx;

    assign w_adv_out  = !r_o_valid || i_ready;
    assign w_issue_ok = !r_s1_valid || w_adv_out;

    // element being issued: first one comes straight from the command
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_cur_elem     = EW'(ELEMENTS - 1);
            w_cur_sub      = SW'(ELEMENTS_PER_BOARD - 1);
            w_cur_addr     = i_cmd.pix_en ? (PW'(LAST_BASE) + PW'(i_cmd.column)) : '0;
            w_cur_use_mem  = i_cmd.pix_en && r_disp_valid;
            w_cur_sel_byte = i_cmd.sel_byte;
        end else begin
            w_cur_elem     = r_elem;
            w_cur_sub      = r_sub;
            w_cur_addr     = r_addr;
            w_cur_use_mem  = r_use_mem;
            w_cur_sel_byte = r_sel_byte;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_scan && w_issue_ok) begin
                    n_state = (w_cur_sub == '0) ? ST_SELECT : ST_PIXEL;
                end
            end
            ST_PIXEL: begin
                if (w_issue_ok) begin
                    n_state = (w_cur_sub == '0) ? ST_SELECT : ST_PIXEL;
                end
            end
            ST_SELECT: begin
                if (w_issue_ok) begin
                    n_state = (r_elem == '0) ? ST_IDLE : ST_PIXEL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_start     = 1'b0;
        w_issue_pix = 1'b0;
        w_issue_sel = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !i_cmd.is_scan) begin
                    o_cmd_pop = 1'b1;
                    w_we      = 1'b1;
                end else if (i_cmd_valid && w_issue_ok) begin
                    o_cmd_pop   = 1'b1;
                    w_start     = 1'b1;
                    w_issue_pix = 1'b1;
                end
            end
            ST_PIXEL: begin
                w_issue_pix = w_issue_ok;
            end
            ST_SELECT: begin
                w_issue_sel = w_issue_ok;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    assign w_re = w_issue_pix && w_cur_use_mem;

    // counter stepping, the select byte follows the first element of a board
    always_comb begin
        n_elem = w_cur_elem;
        n_sub  = w_cur_sub;
        n_addr = w_cur_addr;
        if (w_issue_pix && (w_cur_sub != '0)) begin
            n_elem = w_cur_elem - EW'(1);
            n_sub  = w_cur_sub - SW'(1);
            n_addr = w_cur_addr - PW'(COLUMNS_PER_ELEMENT);
        end else if (w_issue_sel && (r_elem != '0)) begin
            n_elem = r_elem - EW'(1);
            n_sub  = SW'(ELEMENTS_PER_BOARD - 1);
            n_addr = r_addr - PW'(COLUMNS_PER_ELEMENT);
        end
    end

    // load bank is the one not on display
    assign w_wr_idx = (r_show ? MW'(0) : MW'(DB)) + MW'(r_pos);
    assign w_rd_idx = (r_show ? MW'(DB) : MW'(0)) + MW'(w_cur_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_show       <= 1'b0;
            r_disp_valid <= 1'b0;
            r_pos        <= '0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                if (r_pos == PW'(DB - 1)) begin
                    r_pos        <= '0;
                    r_show       <= ~r_show;
                    r_disp_valid <= 1'b1;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            if (w_issue_pix || w_issue_sel) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv_out) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv_out) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue_pix || w_issue_sel) begin
            r_elem <= n_elem;
            r_sub  <= n_sub;
            r_addr <= n_addr;
        end
        if (w_start) begin
            r_use_mem  <= w_cur_use_mem;
            r_sel_byte <= w_cur_sel_byte;
        end
        if (w_issue_pix) begin
            r_s1_use_mem <= w_cur_use_mem;
            r_s1_byte    <= '0;
            r_s1_sel     <= 1'b0;
            r_s1_last    <= 1'b0;
        end else if (w_issue_sel) begin
            r_s1_use_mem <= 1'b0;
            r_s1_byte    <= r_sel_byte;
            r_s1_sel     <= 1'b1;
            r_s1_last    <= (r_elem == '0);
        end
        if (w_adv_out) begin
            r_o_byte <= r_s1_use_mem ? r_rd_data : r_s1_byte;
            r_o_sel  <= r_s1_sel;
            r_o_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx] <= i_cmd.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_shift_byte = r_o_byte;
    assign o_is_select  = r_o_sel;
    assign o_latch      = r_o_last;

`ifndef NO_ASSERTIONS
    a_no_rw_same_cycle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("bitmap write and read in the same cycle");

    a_pos_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(DB - 1))
        else $error("load position out of range");

    a_select_after_board : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SELECT) |-> (r_sub == '0))
        else $error("select byte before end of board");

    a_latch_is_select : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_latch) |-> o_is_select)
        else $error("latch on a pixel byte");

    a_scan_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue_sel && (r_elem == '0)) |=> (r_state == ST_IDLE))
        else $error("scan did not end after the last select byte");
`endif

endmodule

>>> hdl/led_matrix_column_scan_double_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_column_scan_double_buffer_unit
// Double-buffered LED matrix refresher: byte loads fill the hidden bank and
// swap it in when full, column scans stream the shown bank out as
// shift-register bytes with a column-select byte after each board.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | i_valid / o_ready  | i_opcode, i_load_byte, i_column
//   output   | o_valid / i_ready  | o_shift_byte, o_is_select, o_latch
//
// a load writes one byte into the hidden bank and produces no output bytes
// a scan produces ELEMENTS + BOARDS_PER_LINE bytes (21 at defaults), one per
// cycle unless the output side stalls, paced by the single bitmap read port
// and the output register; items pass a front register and a two-entry
// queue, so loads and scans queue up behind a scan that is stalled by the
// output side; no clearing pass after reset: the shown bank reads as zero
// until the first bank swap
// ----------------------------------------------------------------------------
module led_matrix_column_scan_double_buffer_unit #(
    parameter int COLUMNS_PER_ELEMENT = lmcs_pkg::DEF_COLUMNS_PER_ELEMENT,
    parameter int ELEMENTS_PER_BOARD  = lmcs_pkg::DEF_ELEMENTS_PER_BOARD,
    parameter int BOARDS_PER_LINE     = lmcs_pkg::DEF_BOARDS_PER_LINE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [lmcs_pkg::BYTE_W-1:0] i_load_byte,
    input  logic [lmcs_pkg::COL_W-1:0]  i_column,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lmcs_pkg::BYTE_W-1:0] o_shift_byte,
    output logic                        o_is_select,
    output logic                        o_latch
);
    import lmcs_pkg::*;

    logic w_front_valid;
    logic w_front_ready;
    t_cmd w_front_cmd;
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    lmcs_front #(
        .COLUMNS_PER_ELEMENT(COLUMNS_PER_ELEMENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_load_byte (i_load_byte),
        .i_column    (i_column),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    lmcs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_cmd   (w_front_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_cmd    (w_q_cmd)
    );

    lmcs_back #(
        .COLUMNS_PER_ELEMENT(COLUMNS_PER_ELEMENT),
        .ELEMENTS_PER_BOARD (ELEMENTS_PER_BOARD),
        .BOARDS_PER_LINE    (BOARDS_PER_LINE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .o_cmd_pop    (w_q_pop),
        .i_cmd        (w_q_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_shift_byte (o_shift_byte),
        .o_is_select  (o_is_select),
        .o_latch      (o_latch)
    );

endmodule

>>> bench/tb_led_matrix_column_scan_double_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_column_scan_double_buffer_unit
// Self-checking bench for the double-buffered LED matrix column scan unit.
// Load and scan commands are queued up front and driven with bursty timing.
// A bank-swap aware shadow copy of the bitmap predicts every shift byte, and
// the output side stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_led_matrix_column_scan_double_buffer_unit;
    import lmcs_pkg::*;

    localparam int COLS         = DEF_COLUMNS_PER_ELEMENT;
    localparam int EPB          = DEF_ELEMENTS_PER_BOARD;
    localparam int BPL          = DEF_BOARDS_PER_LINE;
    localparam int ELEMENTS     = EPB * BPL;
    localparam int BANK_BYTES   = ELEMENTS * COLS;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] load_byte;
        logic [COL_W-1:0]  column;
    } t_cmd_item;

    typedef struct packed {
        logic [BYTE_W-1:0] shift_byte;
        logic              is_select;
        logic              latch;
    } t_shift_word;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_opcode    = OP_LOAD;
    logic [BYTE_W-1:0] i_load_byte = '0;
    logic [COL_W-1:0]  i_column    = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [BYTE_W-1:0] o_shift_byte;
    logic              o_is_select;
    logic              o_latch;

    // shadow bitmap and bank bookkeeping
    logic [BYTE_W-1:0] bank_mem [2][BANK_BYTES];
    logic              shown_bank;
    int                fill_pos;

    t_cmd_item   pend_q[$];
    t_shift_word shift_exp_q[$];

    int          err_cnt    = 0;
    int          load_cnt   = 0;
    int          scan_cnt   = 0;
    int          swap_cnt   = 0;
    int          bytes_seen = 0;
    int          quiet_cnt  = 0;
    logic        in_fire    = 1'b0;

    // driver state
    t_cmd_item   cur_cmd;
    logic        next_valid;
    int          burst_left = 0;
    int          gap_left   = 0;

    // receiver state
    logic        next_ready;
    int          stall_mode = 0;
    int          mode_left  = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;

    t_shift_word exp_w;

    led_matrix_column_scan_double_buffer_unit #(
        .COLUMNS_PER_ELEMENT(COLS),
        .ELEMENTS_PER_BOARD (EPB),
        .BOARDS_PER_LINE    (BPL)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_load_byte (i_load_byte),
        .i_column    (i_column),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_shift_byte(o_shift_byte),
        .o_is_select (o_is_select),
        .o_latch     (o_latch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // update the shadow bitmap, or queue the bytes a column scan shifts out
    task automatic apply_cmd(input t_cmd_item c);
        logic [BYTE_W-1:0] pix;
        logic [BYTE_W-1:0] sel;
        sel = ~(BYTE_W'(1) << c.column);
        if (c.opcode == OP_LOAD) begin
            load_cnt++;
            bank_mem[~shown_bank][fill_pos] = c.load_byte;
            // last byte of the hidden bank swaps it onto the display at once
            if (fill_pos == BANK_BYTES - 1) begin
                shown_bank = ~shown_bank;
                fill_pos   = 0;
                swap_cnt++;
            end else begin
                fill_pos++;
            end
        end else begin
            scan_cnt++;
            for (int e = ELEMENTS - 1; e >= 0; e--) begin
                pix = '0;
                if (c.column < COLS)
                    pix = bank_mem[shown_bank][e * COLS + c.column];
                shift_exp_q.push_back(t_shift_word'{pix, 1'b0, 1'b0});
                if (e % EPB == 0)
                    shift_exp_q.push_back(t_shift_word'{sel, 1'b1, e == 0});
            end
        end
    endtask

    function automatic void queue_load(input logic [BYTE_W-1:0] b);
        pend_q.push_back(t_cmd_item'{OP_LOAD, b, COL_W'($urandom_range(0, 7))});
    endfunction

    function automatic void queue_scan(input logic [COL_W-1:0] col);
        pend_q.push_back(t_cmd_item'{OP_SCAN, BYTE_W'($urandom_range(0, 255)), col});
    endfunction

    // predictor and checker, sampled at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                apply_cmd(t_cmd_item'{i_opcode, i_load_byte, i_column});
            if (o_valid && i_ready) begin
                bytes_seen++;
                if (shift_exp_q.size() == 0) begin
                    $error("unexpected output transaction: shift_byte %02h", o_shift_byte);
                    err_cnt++;
                end else begin
                    exp_w = shift_exp_q.pop_front();
                    if (o_shift_byte !== exp_w.shift_byte) begin
                        $error("shift_byte expected %02h actual %02h",
                               exp_w.shift_byte, o_shift_byte);
                        err_cnt++;
                    end
                    if (o_is_select !== exp_w.is_select) begin
                        $error("is_select expected %0b actual %0b",
                               exp_w.is_select, o_is_select);
                        err_cnt++;
                    end
                    if (o_latch !== exp_w.latch) begin
                        $error("latch expected %0b actual %0b", exp_w.latch, o_latch);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // sender: bursts of commands separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            next_valid = i_valid && !in_fire;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() != 0) begin
                    cur_cmd = pend_q.pop_front();
                    i_opcode    <= cur_cmd.opcode;
                    i_load_byte <= cur_cmd.load_byte;
                    i_column    <= cur_cmd.column;
                    next_valid  = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // receiver: stall pattern changes after random stretches, one long hold
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && bytes_seen >= HOLD_AT) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = ($urandom_range(0, 3) != 0);
                    default: next_ready = ($urandom_range(0, 9) < 3);
                endcase
            end
            i_ready <= next_ready;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("led_matrix_column_scan_double_buffer_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int n_rand;
        int n_load;

        foreach (bank_mem[b, a])
            bank_mem[b][a] = '0;
        shown_bank = 1'b0;
        fill_pos   = 0;

        // empty display bank, every column select pattern
        for (int c = 0; c < 8; c++)
            queue_scan(COL_W'(c));
        queue_load(8'h00);
        queue_load(8'hff);
        queue_load(8'h01);
        queue_load(8'h80);
        queue_load(8'h55);
        queue_load(8'haa);
        // loads land in the hidden bank, so these still read zero
        queue_scan(3'd0);
        queue_scan(3'd7);
        n_load = 6;

        // mostly loads so that the hidden bank fills and swaps several times
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS || n_load < 2 * BANK_BYTES + 20) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_scan(COL_W'($urandom_range(0, 7)));
            end else begin
                case ($urandom_range(0, 9))
                    0: queue_load(8'h00);
                    1: queue_load(8'hff);
                    default: queue_load(BYTE_W'($urandom_range(0, 255)));
                endcase
                n_load++;
            end
            n_rand++;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (shift_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d loads, %0d column scans, %0d bank swaps", load_cnt, scan_cnt,
                 swap_cnt);
        $display("run: %0d shift bytes compared, %0d mismatches", bytes_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("led_matrix_column_scan_double_buffer_unit verification clean");
        end else begin
            $display("led_matrix_column_scan_double_buffer_unit verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lmcs_pkg.sv
hdl/lmcs_front.sv
hdl/lmcs_queue.sv
hdl/lmcs_back.sv
hdl/led_matrix_column_scan_double_buffer_unit.sv
bench/tb_led_matrix_column_scan_double_buffer_unit.sv
